// ----- src/ult_pkg.sv -----
`timescale 1ns / 1ps

package ult_pkg;

	// characters kept per token; the rest only count
	localparam int MAX_TEXT_CHARS = 8;
	localparam int TEXT_W  = 64;
	localparam int COUNT_W = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_WORD   = 3'd1,
		MODE_PUNCT  = 3'd2,
		MODE_SLASH  = 3'd3,
		MODE_DSLASH = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_CTLD   = 3'd0,
		KIND_TLD    = 3'd1,
		KIND_PROTO  = 3'd2,
		KIND_DOMAIN = 3'd3,
		KIND_PUNC   = 3'd4,
		KIND_DSLASH = 3'd5
	} kind_t;

	// keywords packed the way token text is: first char in the top byte
	localparam logic [TEXT_W-1:0] KW_PK    = {"pk",    48'd0};
	localparam logic [TEXT_W-1:0] KW_COM   = {"com",   40'd0};
	localparam logic [TEXT_W-1:0] KW_ORG   = {"org",   40'd0};
	localparam logic [TEXT_W-1:0] KW_EDU   = {"edu",   40'd0};
	localparam logic [TEXT_W-1:0] KW_WWW   = {"www",   40'd0};
	localparam logic [TEXT_W-1:0] KW_HTTP  = {"http",  32'd0};
	localparam logic [TEXT_W-1:0] KW_HTTPS = {"https", 24'd0};

	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_COLON = ":";
	localparam logic [7:0] CH_SLASH = "/";

	typedef struct packed {
		kind_t               kind;
		logic [COUNT_W-1:0]  length;
		logic [TEXT_W-1:0]   text;
		logic                truncated;
	} token_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	// store c at position count if there is room
	function automatic logic [TEXT_W-1:0] append_char(input logic [TEXT_W-1:0] chars,
			input logic [COUNT_W-1:0] count, input logic [7:0] c);
		logic [TEXT_W-1:0] r;
		r = chars;
		for (int i = 0; i < MAX_TEXT_CHARS; i++) begin
			if (count == COUNT_W'(i))
				r[TEXT_W-1-8*i -: 8] = r[TEXT_W-1-8*i -: 8] | c;
		end
		return r;
	endfunction

	function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] count);
		return (count == COUNT_MAX) ? count : count + COUNT_W'(1);
	endfunction

endpackage

// ----- src/url_token_lexer.sv -----
`timescale 1ns / 1ps
// URL token lexer: one ASCII byte per word in, zero or one token per byte out.
// The byte that ends a token is held in the input register s1; the token then goes into the output register.
// Throughput: one byte per cycle while the input is not stalled; the lexer state updates once per byte.
// Input stalls only while the output register holds a token the sink is stalling.
// Reset (arst_n low, async): lexer idle, token buffer and count cleared, no output.

module url_token_lexer import ult_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_kind,
	output logic [7:0]  token_length,
	output logic [63:0] token_text,
	output logic        text_truncated
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// output register
	logic   out_valid_q;
	token_t token_q;

	logic   out_free;   // output register can take a new token this cycle
	logic   step;       // byte in s1 goes through the lexer
	logic   accept;
	logic   emit;
	token_t token;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	// s1 refills in the cycle it drains, so only a blocked s1 stalls input
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end

	ult_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.c      (byte_s1),
		.emit   (emit),
		.token  (token)
	);

	// a byte that ends nothing leaves the register empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			token_q <= token;
		end
	end

	assign out_valid      = out_valid_q;
	assign token_kind     = token_q.kind;
	assign token_length   = token_q.length;
	assign token_text     = token_q.text;
	assign text_truncated = token_q.truncated;

endmodule

// ----- src/ult_classify.sv -----
`timescale 1ns / 1ps

module ult_classify import ult_pkg::*; (
	input  logic [TEXT_W-1:0]  chars,
	input  logic [COUNT_W-1:0] count,
	output kind_t              kind
);

	logic len2, len3, len4, len5;

	assign len2 = (count == COUNT_W'(2));
	assign len3 = (count == COUNT_W'(3));
	assign len4 = (count == COUNT_W'(4));
	assign len5 = (count == COUNT_W'(5));

	always_comb begin
		if (len2 && chars == KW_PK) begin
			kind = KIND_CTLD;
		end else if (len3 && (chars == KW_COM || chars == KW_ORG || chars == KW_EDU)) begin
			kind = KIND_TLD;
		end else if ((len3 && chars == KW_WWW) || (len4 && chars == KW_HTTP) ||
				(len5 && chars == KW_HTTPS)) begin
			kind = KIND_PROTO;
		end else begin
			kind = KIND_DOMAIN;
		end
	end

endmodule

// ----- src/ult_core.sv -----
`timescale 1ns / 1ps

module ult_core import ult_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] c,
	output logic       emit,
	output token_t     token
);

	mode_t              mode_q, mode_n;
	logic [TEXT_W-1:0]  chars_q, chars_n;
	logic [COUNT_W-1:0] count_q, count_n;
	kind_t              word_kind;
	logic               restart;

	ult_classify u_classify (
		.chars (chars_q),
		.count (count_q),
		.kind  (word_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			chars_q <= '0;
			count_q <= '0;
		end else if (step) begin
			mode_q  <= mode_n;
			chars_q <= chars_n;
			count_q <= count_n;
		end
	end

	always_comb begin
		mode_n     = mode_q;
		chars_n    = chars_q;
		count_n    = count_q;
		emit       = 1'b0;
		restart    = 1'b0;
		token.kind = word_kind;
		token.length    = count_q;
		token.text      = chars_q;
		token.truncated = (count_q > COUNT_W'(MAX_TEXT_CHARS));

		case (mode_q)
			MODE_WORD: begin
				if (is_letter(c)) begin
					chars_n = append_char(chars_q, count_q, c);
					count_n = count_inc(count_q);
				end else begin
					emit    = 1'b1;
					restart = 1'b1;
				end
			end
			MODE_PUNCT: begin
				emit       = 1'b1;
				token.kind = KIND_PUNC;
				restart    = 1'b1;
			end
			MODE_DSLASH: begin
				emit       = 1'b1;
				token.kind = KIND_DSLASH;
				restart    = 1'b1;
			end
			MODE_SLASH: begin
				// wait for the second slash, drop anything else
				if (c == CH_SLASH) begin
					chars_n = append_char(chars_q, count_q, c);
					count_n = count_inc(count_q);
					mode_n  = MODE_DSLASH;
				end
			end
			default: begin
				restart = 1'b1;
			end
		endcase

		// the ending byte starts the next token in the same step
		if (restart) begin
			chars_n = '0;
			count_n = '0;
			mode_n  = MODE_IDLE;
			if (is_letter(c)) begin
				chars_n = {c, {(TEXT_W-8){1'b0}}};
				count_n = COUNT_W'(1);
				mode_n  = MODE_WORD;
			end else if (c == CH_DOT || c == CH_COLON) begin
				chars_n = {c, {(TEXT_W-8){1'b0}}};
				count_n = COUNT_W'(1);
				mode_n  = MODE_PUNCT;
			end else if (c == CH_SLASH) begin
				chars_n = {c, {(TEXT_W-8){1'b0}}};
				count_n = COUNT_W'(1);
				mode_n  = MODE_SLASH;
			end
		end
	end

endmodule
